@@ rtl/binary_map_ray_path_length_defines.svh @@
// ============================================================================
// Assertion macros for the ray path length block
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ============================================================================
`ifndef BINARY_MAP_RAY_PATH_LENGTH_DEFINES_SVH
`define BINARY_MAP_RAY_PATH_LENGTH_DEFINES_SVH
`ifndef ASSERT_OFF
// Check that is disabled while reset is asserted.
`define BMRPL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that holds in and out of reset.
`define BMRPL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMRPL_ASSERT(lbl, prop, msg)
`define BMRPL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/bmrpl_pkg.sv @@
// ============================================================================
// Ray path length package
// Shared constants, register indexes and control structs.
// ============================================================================
`default_nettype none

package bmrpl_pkg;

    localparam int MAP_MAX_COLS_DEF = 2048;
    localparam int MAP_MAX_ROWS_DEF = 2048;
    localparam int STEP_MAX_DEF     = 4096;

    // Position accumulators carry 26 fractional bits (Q4.12 times Q1.14).
    localparam int FRAC_BITS = 26;
    localparam int INC_W     = 33;
    localparam int ELEV_W    = 32;
    localparam int COUNT_W   = 13;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PIXELS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_STEPS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 3'd7;

    localparam logic [10:0] ORIGIN_X_RST       = 11'd915;
    localparam logic [10:0] ORIGIN_Y_RST       = 11'd1116;
    localparam logic [11:0] MAP_COLS_RST       = 12'd2048;
    localparam logic [11:0] MAP_ROWS_RST       = 12'd2048;
    localparam logic [11:0] LAST_STEP_RST      = 12'd300;
    localparam logic [15:0] STEP_PIXELS_RST    = 16'd3072;
    localparam logic [15:0] SURFACE_STEPS_RST  = 16'd150;
    localparam logic [7:0]  DARK_THRESHOLD_RST = 8'd128;

    // Control bits that travel with each sample down the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
        logic ok;
    } sample_ctl_t;

    // Per-sample verdict delivered to the counter.
    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } sample_res_t;

endpackage

`default_nettype wire

@@ rtl/bmrpl_sample_pipe.sv @@
// ============================================================================
// Ray sample pipeline
// Rounds sample positions, checks map bounds, forms the pixel address and
// reads the grey map; holds the map memory and its load port.
// ============================================================================
`default_nettype none

module bmrpl_sample_pipe #(
    parameter int MAP_MAX_COLS = bmrpl_pkg::MAP_MAX_COLS_DEF,
    parameter int MAP_MAX_ROWS = bmrpl_pkg::MAP_MAX_ROWS_DEF,
    parameter int STEP_MAX     = bmrpl_pkg::STEP_MAX_DEF,
    localparam int WALK_W      = 39 + $clog2(STEP_MAX),
    localparam int COL_W       = $clog2(MAP_MAX_COLS + 1),
    localparam int ROW_W       = $clog2(MAP_MAX_ROWS + 1),
    localparam int ADDR_W      = $clog2(MAP_MAX_COLS * MAP_MAX_ROWS)
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        adv,
    input  wire [COL_W-1:0]            cols,
    input  wire [ROW_W-1:0]            rows,
    input  wire [7:0]                  dark_threshold,
    input  wire                        wr_en,
    input  wire [ADDR_W-1:0]           wr_addr,
    input  wire [7:0]                  wr_data,
    input  bmrpl_pkg::sample_ctl_t     s0_ctl,
    input  wire signed [WALK_W-1:0]    acc_x,
    input  wire signed [WALK_W-1:0]    acc_y,
    output bmrpl_pkg::sample_res_t     res
);

    localparam int DEPTH = MAP_MAX_COLS * MAP_MAX_ROWS;
    localparam int RND_W = WALK_W - bmrpl_pkg::FRAC_BITS;
    localparam int PX_W  = $clog2(MAP_MAX_COLS);
    localparam int PY_W  = $clog2(MAP_MAX_ROWS);
    localparam int PROD_W = PY_W + COL_W;
    localparam logic [WALK_W-1:0] HALF = {{RND_W{1'b0}}, 1'b1,
                                          {(bmrpl_pkg::FRAC_BITS - 1){1'b0}}};

    logic [7:0] mem [DEPTH];

    // Stage 1: sign and magnitude of each accumulator.
    bmrpl_pkg::sample_ctl_t ctl1_reg;
    logic                   neg_x1_reg, neg_y1_reg;
    logic [WALK_W-1:0]      mag_x1_reg, mag_y1_reg;
    logic [WALK_W-1:0]      mag_x1_next, mag_y1_next;

    // Stage 2: rounded pixel coordinates and the inside-map flag.
    bmrpl_pkg::sample_ctl_t ctl2_reg;
    logic [PX_W-1:0]        px2_reg;
    logic [PY_W-1:0]        py2_reg;
    logic [WALK_W-1:0]      sum_x, sum_y;
    logic [RND_W-1:0]       rnd_x, rnd_y;
    logic                   in_x, in_y;

    // Stage 3: row offset product.
    bmrpl_pkg::sample_ctl_t ctl3_reg;
    logic [PX_W-1:0]        px3_reg;
    logic [PROD_W-1:0]      prod3_reg;
    logic [ADDR_W-1:0]      rd_addr;

    // Stage 4: registered map data.
    bmrpl_pkg::sample_ctl_t ctl4_reg;
    logic [7:0]             rd_data4_reg;

    always_comb
    begin
        mag_x1_next = acc_x[WALK_W-1] ? -acc_x : acc_x;
        mag_y1_next = acc_y[WALK_W-1] ? -acc_y : acc_y;
    end

    // Rounding is half away from zero, so a negative accumulator whose
    // magnitude rounds to zero still lands on pixel zero.
    always_comb
    begin
        sum_x = mag_x1_reg + HALF;
        sum_y = mag_y1_reg + HALF;
        rnd_x = sum_x[WALK_W-1:bmrpl_pkg::FRAC_BITS];
        rnd_y = sum_y[WALK_W-1:bmrpl_pkg::FRAC_BITS];
        in_x  = !(neg_x1_reg && (rnd_x != '0)) && (rnd_x < RND_W'(cols));
        in_y  = !(neg_y1_reg && (rnd_y != '0)) && (rnd_y < RND_W'(rows));
    end

    assign rd_addr = ADDR_W'(prod3_reg + PROD_W'(px3_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= s0_ctl;
            ctl2_reg <= '{valid: ctl1_reg.valid, last: ctl1_reg.last,
                          ok: ctl1_reg.ok && in_x && in_y};
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_x1_reg <= acc_x[WALK_W-1];
            neg_y1_reg <= acc_y[WALK_W-1];
            mag_x1_reg <= mag_x1_next;
            mag_y1_reg <= mag_y1_next;
            px2_reg    <= PX_W'(rnd_x);
            py2_reg    <= PY_W'(rnd_y);
            px3_reg    <= px2_reg;
            prod3_reg  <= PROD_W'(py2_reg * cols);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Only samples inside the map read the memory.
    always_ff @(posedge clk)
    begin
        if (adv && ctl3_reg.ok)
        begin
            rd_data4_reg <= mem[rd_addr];
        end
    end

    assign res = '{valid: ctl4_reg.valid, last: ctl4_reg.last,
                   hit: ctl4_reg.ok && (rd_data4_reg < dark_threshold)};

endmodule

`default_nettype wire

@@ rtl/binary_map_ray_path_length.sv @@
// ============================================================================
// Binary map ray path length
// Fixed-step ray marcher that counts dark map samples below the surface.
// ============================================================================
// A load item (kind 0) writes one pixel of the grey map, and loads may follow
// each other in every cycle while no cast is in progress. A cast item (kind 1)
// walks one ray: the walker issues one sample per cycle into the sample
// pipeline while the output is not stalled, and the block takes no new item
// until the last sample of the ray has left the pipeline. The result sits in
// an output register, so the next item is taken while it waits. The map is
// not cleared after reset; pixels must be loaded before any ray reads them.
`default_nettype none

`include "binary_map_ray_path_length_defines.svh"

module binary_map_ray_path_length #(
    parameter int MAP_MAX_COLS = bmrpl_pkg::MAP_MAX_COLS_DEF,
    parameter int MAP_MAX_ROWS = bmrpl_pkg::MAP_MAX_ROWS_DEF,
    parameter int STEP_MAX     = bmrpl_pkg::STEP_MAX_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [bmrpl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [bmrpl_pkg::CFG_W-1:0]       cfg_data,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire                              kind,
    input  wire [21:0]                       pixel_index,
    input  wire [7:0]                        pixel_value,
    input  wire signed [15:0]                dir_x,
    input  wire signed [15:0]                dir_y,
    input  wire [15:0]                       tan_elev,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [bmrpl_pkg::COUNT_W-1:0]    rock_steps
);

    localparam int WALK_W    = 39 + $clog2(STEP_MAX);
    localparam int STEP_W    = $clog2(STEP_MAX);
    localparam int COL_W     = $clog2(MAP_MAX_COLS + 1);
    localparam int ROW_W     = $clog2(MAP_MAX_ROWS + 1);
    localparam int DEPTH     = MAP_MAX_COLS * MAP_MAX_ROWS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int IDX_CMP_W = (ADDR_W > 22 ? ADDR_W : 22) + 1;
    localparam int FRAC      = bmrpl_pkg::FRAC_BITS;
    localparam int INC_W     = bmrpl_pkg::INC_W;
    localparam int ELEV_W    = bmrpl_pkg::ELEV_W;
    localparam int COUNT_W   = bmrpl_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } walk_state_t;

    // Configuration registers.
    logic [10:0] origin_x_reg, origin_y_reg;
    logic [11:0] map_cols_reg, map_rows_reg, last_step_reg;
    logic [15:0] step_pixels_reg, surface_steps_reg;
    logic [7:0]  dark_threshold_reg;

    // Walker state.
    walk_state_t              state_reg, state_next;
    logic signed [WALK_W-1:0] walk_x_reg, walk_y_reg;
    logic signed [INC_W-1:0]  inc_x_reg, inc_y_reg;
    logic [ELEV_W-1:0]        elev_sum_reg;
    logic [15:0]              tan_reg;
    logic [STEP_W-1:0]        step_index_reg;
    logic [COUNT_W-1:0]       hit_count_reg, hit_count_next;
    logic                     out_valid_reg;
    logic [COUNT_W-1:0]       out_data_reg;

    logic                   in_acc, cast_acc, adv, ray_done;
    logic [COL_W-1:0]       cols_sat;
    logic [ROW_W-1:0]       rows_sat;
    logic [STEP_W-1:0]      last_sat;
    logic                   wr_en;
    bmrpl_pkg::sample_ctl_t s0_ctl;
    bmrpl_pkg::sample_res_t res;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign cast_acc = in_acc && kind;
    assign adv      = !out_valid_reg || !out_stall;
    assign ray_done = adv && res.valid && res.last;
    assign wr_en    = in_acc && !kind && (IDX_CMP_W'(pixel_index) < IDX_CMP_W'(DEPTH));

    // Oversized map dimensions and step counts saturate to the built maximum.
    always_comb
    begin
        cols_sat = (32'(map_cols_reg) > 32'(MAP_MAX_COLS)) ? COL_W'(MAP_MAX_COLS)
                                                          : COL_W'(map_cols_reg);
        rows_sat = (32'(map_rows_reg) > 32'(MAP_MAX_ROWS)) ? ROW_W'(MAP_MAX_ROWS)
                                                          : ROW_W'(map_rows_reg);
        last_sat = (32'(last_step_reg) > 32'(STEP_MAX - 1)) ? STEP_W'(STEP_MAX - 1)
                                                            : STEP_W'(last_step_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg       <= bmrpl_pkg::ORIGIN_X_RST;
            origin_y_reg       <= bmrpl_pkg::ORIGIN_Y_RST;
            map_cols_reg       <= bmrpl_pkg::MAP_COLS_RST;
            map_rows_reg       <= bmrpl_pkg::MAP_ROWS_RST;
            last_step_reg      <= bmrpl_pkg::LAST_STEP_RST;
            step_pixels_reg    <= bmrpl_pkg::STEP_PIXELS_RST;
            surface_steps_reg  <= bmrpl_pkg::SURFACE_STEPS_RST;
            dark_threshold_reg <= bmrpl_pkg::DARK_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bmrpl_pkg::REG_ORIGIN_X:       origin_x_reg       <= cfg_data[10:0];
                bmrpl_pkg::REG_ORIGIN_Y:       origin_y_reg       <= cfg_data[10:0];
                bmrpl_pkg::REG_MAP_COLS:       map_cols_reg       <= cfg_data[11:0];
                bmrpl_pkg::REG_MAP_ROWS:       map_rows_reg       <= cfg_data[11:0];
                bmrpl_pkg::REG_LAST_STEP:      last_step_reg      <= cfg_data[11:0];
                bmrpl_pkg::REG_STEP_PIXELS:    step_pixels_reg    <= cfg_data;
                bmrpl_pkg::REG_SURFACE_STEPS:  surface_steps_reg  <= cfg_data;
                bmrpl_pkg::REG_DARK_THRESHOLD: dark_threshold_reg <= cfg_data[7:0];
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cast_acc)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (adv && (step_index_reg == last_sat))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (ray_done)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The walker register set is the sample that enters the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_x_reg     <= '0;
            walk_y_reg     <= '0;
            elev_sum_reg   <= '0;
            step_index_reg <= '0;
        end
        else if (cast_acc)
        begin
            walk_x_reg     <= WALK_W'($signed({1'b0, origin_x_reg, {FRAC{1'b0}}}));
            walk_y_reg     <= WALK_W'($signed({1'b0, origin_y_reg, {FRAC{1'b0}}}));
            elev_sum_reg   <= '0;
            step_index_reg <= '0;
        end
        else if ((state_reg == ST_RUN) && adv && (step_index_reg != last_sat))
        begin
            walk_x_reg     <= walk_x_reg + WALK_W'(inc_x_reg);
            walk_y_reg     <= walk_y_reg + WALK_W'(inc_y_reg);
            elev_sum_reg   <= elev_sum_reg + ELEV_W'(tan_reg);
            step_index_reg <= step_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cast_acc)
        begin
            inc_x_reg <= $signed({1'b0, step_pixels_reg}) * dir_x;
            inc_y_reg <= $signed({1'b0, step_pixels_reg}) * dir_y;
            tan_reg   <= tan_elev;
        end
    end

    assign s0_ctl = '{valid: (state_reg == ST_RUN),
                      last:  (step_index_reg == last_sat),
                      ok:    (elev_sum_reg <= {surface_steps_reg, 16'h0000})};

    bmrpl_sample_pipe #(
        .MAP_MAX_COLS (MAP_MAX_COLS),
        .MAP_MAX_ROWS (MAP_MAX_ROWS),
        .STEP_MAX     (STEP_MAX)
    ) u_pipe (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .cols           (cols_sat),
        .rows           (rows_sat),
        .dark_threshold (dark_threshold_reg),
        .wr_en          (wr_en),
        .wr_addr        (ADDR_W'(pixel_index)),
        .wr_data        (pixel_value),
        .s0_ctl         (s0_ctl),
        .acc_x          (walk_x_reg),
        .acc_y          (walk_y_reg),
        .res            (res)
    );

    assign hit_count_next = hit_count_reg + COUNT_W'(res.hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_count_reg <= '0;
        end
        else if (cast_acc)
        begin
            hit_count_reg <= '0;
        end
        else if (adv && res.valid)
        begin
            hit_count_reg <= hit_count_next;
        end
    end

    // The output register frees up in the same cycle its result transfers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ray_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ray_done)
        begin
            out_data_reg <= hit_count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign rock_steps = out_data_reg;

    `BMRPL_ASSERT_ALWAYS(a_idle_pipe_empty, (state_reg == ST_IDLE) |-> !res.valid,
        "sample pipeline holds a sample while the walker is idle")
    `BMRPL_ASSERT(a_last_in_drain, (res.valid && res.last) |-> (state_reg == ST_DRAIN),
        "final sample of a ray arrived outside the drain phase")
    `BMRPL_ASSERT(a_cast_start,
        cast_acc |=> ((state_reg == ST_RUN) && (step_index_reg == '0) && (hit_count_reg == '0)),
        "cast did not start a fresh walk")
    `BMRPL_ASSERT(a_step_bound, (state_reg == ST_RUN) |-> (step_index_reg <= last_sat),
        "walker stepped past the final sample")

endmodule

`default_nettype wire
